// ===== design/dspp_pkg.sv =====
// shared types and constants for the serial and printer port register block
package dspp_pkg;

   localparam int TickPeriodDefault = 100;
   localparam logic [16:0] BaudClock = 17'd125000;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [3:0] PORT_A_DATA = 4'd0;
   localparam logic [3:0] PORT_A_CTRL = 4'd1;
   localparam logic [3:0] PORT_B_DATA = 4'd2;
   localparam logic [3:0] PORT_B_CTRL = 4'd3;
   localparam logic [3:0] PORT_BAUD_LO = 4'd4;
   localparam logic [3:0] PORT_BAUD_HI = 4'd5;
   localparam logic [3:0] PORT_BAUD_MODE = 4'd7;
   localparam logic [3:0] PORT_PRINT = 4'd8;

   localparam logic [7:0] BAUD_ARM_TX = 8'h36;
   localparam logic [7:0] BAUD_ARM_RX = 8'h76;

   localparam logic [1:0] BAUD_NONE = 2'd0;
   localparam logic [1:0] BAUD_TX = 2'd1;
   localparam logic [1:0] BAUD_RX = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;       // latch the request and do the register work
      logic div_start;  // load the divider
      logic div_step;   // one quotient bit
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

   function automatic logic [1:0] len_code(input logic [1:0] c);
      case (c)
         2'd0: len_code = 2'd0;
         2'd1: len_code = 2'd2;
         2'd2: len_code = 2'd1;
         default: len_code = 2'd3;
      endcase
   endfunction

endpackage

// ===== design/dspp_ctrl.sv =====
// controller state machine: accept, divide, hold the result word
module dspp_ctrl
   import dspp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIVIDE;
            end else begin
               rsp_valid = 1'b1;
               if (!rsp_stall) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== design/dspp_path.sv =====
// datapath: channel registers, baud loader, printer latch, tick timer, divider
module dspp_path
   import dspp_pkg::*;
#(
   parameter int TICK_PERIOD = TickPeriodDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        csr_write,
   input  logic        csr_wdata,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_port,
   input  logic [7:0]  req_wdata,
   input  logic        req_rx_available,
   input  logic        req_clear_to_send,
   input  logic        req_tx_empty,
   input  logic        req_all_sent,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_printer_busy,
   output logic [7:0]  rsp_rdata,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_send_valid,
   output logic        rsp_print_valid,
   output logic        rsp_rx_pop,
   output logic [1:0]  rsp_baud_kind,
   output logic [16:0] rsp_baud_rate,
   output logic        rsp_irq_pulse,
   output logic        rsp_break_pulse,
   output logic [1:0]  rsp_modem_lines,
   output logic [3:0]  rsp_char_lengths,
   output logic [3:0]  rsp_parity_stop
);

   localparam logic [6:0] Period = 7'(TICK_PERIOD);

   logic       en_ff;
   logic       a_phase_ff, b_phase_ff;
   logic [2:0] a_ptr_ff, b_ptr_ff;
   logic [7:0] a_regs_ff [8];
   logic [7:0] b_regs_ff [8];
   logic [7:0] a_st0_ff, a_st1_ff, b_st0_ff, a_latch_ff, b_latch_ff;
   logic [2:0] baud_step_ff;
   logic [7:0] baud_lo_ff, print_char_ff;
   logic [6:0] tick_ff;
   logic [9:0] rep_ff;

   logic [7:0] rdata_ff, out_ff;
   logic       send_ff, print_ff, pop_ff, irq_ff, brk_ff, need_div_ff;
   logic [1:0] bkind_ff;

   // divider: restoring, one quotient bit per cycle
   logic [15:0] divisor_ff;
   logic [16:0] quot_ff;
   logic [16:0] rem_ff;
   logic [4:0]  div_cnt_ff;

   // combinational next state for one item
   logic       a_phase_in, b_phase_in;
   logic [2:0] a_ptr_in, b_ptr_in;
   logic [7:0] a_regs_in [8];
   logic [7:0] b_regs_in [8];
   logic [7:0] a_st0_in, a_st1_in, b_st0_in, a_latch_in, b_latch_in;
   logic [2:0] baud_step_in;
   logic [7:0] baud_lo_in, print_char_in;
   logic [6:0] tick_in;
   logic [9:0] rep_in;
   logic [7:0] rdata_in, out_in;
   logic       send_in, print_in, pop_in, irq_in, brk_in, need_div_in;
   logic [1:0] bkind_in;
   logic [15:0] count_in;

   logic       a_wr, b_wr;
   logic [2:0] a_reg, b_reg;
   logic [7:0] a_old, a_diff;
   logic [2:0] rd_reg;
   logic [6:0] tick_inc;
   logic [17:0] trial;

   always_comb begin
      a_phase_in = a_phase_ff; b_phase_in = b_phase_ff;
      a_ptr_in = a_ptr_ff; b_ptr_in = b_ptr_ff;
      a_regs_in = a_regs_ff; b_regs_in = b_regs_ff;
      a_st0_in = a_st0_ff; a_st1_in = a_st1_ff; b_st0_in = b_st0_ff;
      a_latch_in = a_latch_ff; b_latch_in = b_latch_ff;
      baud_step_in = baud_step_ff; baud_lo_in = baud_lo_ff;
      print_char_in = print_char_ff; tick_in = tick_ff; rep_in = rep_ff;
      rdata_in = 8'hFF; out_in = 8'h00;
      send_in = 1'b0; print_in = 1'b0; pop_in = 1'b0; irq_in = 1'b0;
      brk_in = 1'b0; need_div_in = 1'b0; bkind_in = BAUD_NONE;
      count_in = {req_wdata, baud_lo_ff};
      a_wr = 1'b0; b_wr = 1'b0; a_reg = 3'd0; b_reg = 3'd0;
      a_old = 8'h00; a_diff = 8'h00; rd_reg = 3'd0;
      tick_inc = tick_ff;

      if (req_kind == KIND_READ && en_ff) begin
         case (req_port)
            PORT_A_DATA: begin
               a_latch_in = req_rx_byte; rdata_in = req_rx_byte; pop_in = 1'b1;
            end
            PORT_A_CTRL: begin
               rd_reg = a_phase_ff ? a_ptr_ff : 3'd0;
               a_phase_in = 1'b0;
               if (rd_reg == 3'd0) begin
                  a_st0_in = (a_st0_ff & ~8'h25) | {2'b00, req_clear_to_send, 2'b00,
                             req_tx_empty, 1'b0, req_rx_available};
                  rdata_in = a_st0_in;
               end else if (rd_reg == 3'd1) begin
                  a_st1_in = {7'd0, req_all_sent};
                  rdata_in = a_st1_in;
               end else if (rd_reg == 3'd2) begin
                  rdata_in = a_regs_ff[2];
               end
            end
            PORT_B_DATA: rdata_in = b_latch_ff;
            PORT_B_CTRL: begin
               rd_reg = b_phase_ff ? b_ptr_ff : 3'd0;
               b_phase_in = 1'b0;
               if (rd_reg == 3'd0) begin
                  b_st0_in = (b_st0_ff & ~8'h20) | {2'b00, ~req_printer_busy, 5'd0};
                  rdata_in = b_st0_in;
               end else if (rd_reg == 3'd1) begin
                  rdata_in = 8'h00;
               end else if (rd_reg == 3'd2) begin
                  rdata_in = b_regs_ff[2];
               end
            end
            default: ;
         endcase
      end else if (req_kind == KIND_WRITE && en_ff) begin
         case (req_port)
            PORT_A_DATA: begin
               a_latch_in = req_wdata; out_in = req_wdata; send_in = 1'b1;
            end
            PORT_A_CTRL: begin
               if (!a_phase_ff) begin
                  a_ptr_in = req_wdata[2:0];
                  if (req_wdata[2:0] != 3'd0) a_phase_in = 1'b1;
                  else a_wr = 1'b1;
                  a_reg = 3'd0;
               end else begin
                  a_phase_in = 1'b0; a_wr = 1'b1; a_reg = a_ptr_ff;
               end
            end
            PORT_B_DATA: b_latch_in = req_wdata;
            PORT_B_CTRL: begin
               if (!b_phase_ff) begin
                  b_ptr_in = req_wdata[2:0];
                  if (req_wdata[2:0] != 3'd0) b_phase_in = 1'b1;
                  else b_wr = 1'b1;
                  b_reg = 3'd0;
               end else begin
                  b_phase_in = 1'b0; b_wr = 1'b1; b_reg = b_ptr_ff;
               end
            end
            PORT_BAUD_LO, PORT_BAUD_HI: begin
               if (baud_step_ff == 3'd1 || baud_step_ff == 3'd3) begin
                  baud_lo_in = req_wdata;
                  baud_step_in = baud_step_ff + 3'd1;
               end else if (baud_step_ff == 3'd2 || baud_step_ff == 3'd4) begin
                  bkind_in = (baud_step_ff == 3'd2) ? BAUD_TX : BAUD_RX;
                  need_div_in = (count_in != 16'd0);
                  baud_step_in = 3'd0;
               end
            end
            PORT_BAUD_MODE: begin
               if (req_wdata == BAUD_ARM_TX) baud_step_in = 3'd1;
               else if (req_wdata == BAUD_ARM_RX) baud_step_in = 3'd3;
            end
            PORT_PRINT: print_char_in = req_wdata;
            default: ;
         endcase

         if (a_wr) begin
            a_old = a_regs_ff[a_reg];
            a_diff = a_old ^ req_wdata;
            if (a_reg == 3'd5) begin
               if (a_diff[1]) rep_in[0] = req_wdata[1];
               if (a_diff[4] && req_wdata[4]) brk_in = 1'b1;
               if (a_diff[6] || a_diff[5]) rep_in[3:2] = len_code(req_wdata[6:5]);
               if (a_diff[7]) rep_in[1] = req_wdata[7];
            end else if (a_reg == 3'd4) begin
               if (a_diff[1:0] != 2'd0)
                  rep_in[7:6] = (req_wdata[1:0] == 2'd1) ? 2'd1 :
                                ((req_wdata[1:0] == 2'd3) ? 2'd2 : 2'd0);
               if (a_diff[3:2] != 2'd0 && req_wdata[3:2] != 2'd0)
                  rep_in[9:8] = req_wdata[3:2] - 2'd1;
            end else if (a_reg == 3'd3) begin
               if (a_diff[7:6] != 2'd0) rep_in[5:4] = len_code(req_wdata[7:6]);
            end
            if (a_reg == 3'd0 && req_wdata[7:3] == 5'd3) begin
               a_phase_in = 1'b0; a_ptr_in = 3'd0; a_latch_in = 8'h00;
               for (int i = 0; i < 8; i++) a_regs_in[i] = 8'h00;
               a_st0_in = 8'h00; a_st1_in = 8'h00;
            end
            a_regs_in[a_reg] = req_wdata;
         end

         if (b_wr) begin
            if (b_reg == 3'd0 && req_wdata[7:3] == 5'd3) begin
               b_phase_in = 1'b0; b_ptr_in = 3'd0; b_latch_in = 8'h00;
               for (int i = 0; i < 8; i++) b_regs_in[i] = 8'h00;
               b_st0_in = 8'h00;
            end
            b_regs_in[b_reg] = req_wdata;
            // strobe falling edge emits the printer character
            if (b_reg == 3'd5 && b_regs_ff[5][7] && !req_wdata[7]) begin
               print_in = 1'b1; out_in = print_char_ff;
            end
         end
      end else if (req_kind == KIND_TICK) begin
         if (tick_ff < Period) tick_inc = tick_ff + 7'd1;
         tick_in = tick_inc;
         if (tick_inc >= Period && en_ff && (a_regs_ff[1][4] || a_regs_ff[1][3])) begin
            if (req_rx_available) begin
               irq_in = 1'b1; a_st0_in = a_st0_ff | 8'h03;
            end else begin
               a_st0_in = a_st0_ff & ~8'h03;
            end
            tick_in = 7'd0;
         end
      end
   end

   assign trial = {rem_ff, quot_ff[16]} - {2'b00, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b1;
         a_phase_ff <= 1'b0; b_phase_ff <= 1'b0;
         a_ptr_ff <= 3'd0; b_ptr_ff <= 3'd0;
         for (int i = 0; i < 8; i++) begin
            a_regs_ff[i] <= 8'h00; b_regs_ff[i] <= 8'h00;
         end
         a_st0_ff <= 8'h00; a_st1_ff <= 8'h00; b_st0_ff <= 8'h00;
         a_latch_ff <= 8'h00; b_latch_ff <= 8'h00;
         baud_step_ff <= 3'd0; baud_lo_ff <= 8'h00; print_char_ff <= 8'hFF;
         tick_ff <= 7'd0; rep_ff <= 10'd0;
         need_div_ff <= 1'b0;
      end else begin
         if (csr_write) en_ff <= csr_wdata;
         if (cmd.take) begin
            a_phase_ff <= a_phase_in; b_phase_ff <= b_phase_in;
            a_ptr_ff <= a_ptr_in; b_ptr_ff <= b_ptr_in;
            a_regs_ff <= a_regs_in; b_regs_ff <= b_regs_in;
            a_st0_ff <= a_st0_in; a_st1_ff <= a_st1_in; b_st0_ff <= b_st0_in;
            a_latch_ff <= a_latch_in; b_latch_ff <= b_latch_in;
            baud_step_ff <= baud_step_in; baud_lo_ff <= baud_lo_in;
            print_char_ff <= print_char_in; tick_ff <= tick_in; rep_ff <= rep_in;
            need_div_ff <= need_div_in;
         end else if (cmd.div_start) begin
            need_div_ff <= 1'b0;
         end
      end
   end

   // result word and divider, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rdata_ff <= rdata_in; out_ff <= out_in; send_ff <= send_in;
         print_ff <= print_in; pop_ff <= pop_in; irq_ff <= irq_in;
         brk_ff <= brk_in; bkind_ff <= bkind_in;
         divisor_ff <= count_in;
         quot_ff <= 17'd0;
      end else if (cmd.div_start) begin
         quot_ff <= BaudClock;
         rem_ff <= 17'd0;
         div_cnt_ff <= 5'd0;
      end else if (cmd.div_step) begin
         if (!trial[17]) begin
            rem_ff <= trial[16:0];
            quot_ff <= {quot_ff[15:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[15:0], quot_ff[16]};
            quot_ff <= {quot_ff[15:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff + 5'd1;
      end
   end

   assign status.need_div = need_div_ff;
   assign status.div_last = (div_cnt_ff == 5'd16);

   assign rsp_rdata = rdata_ff;
   assign rsp_out_byte = out_ff;
   assign rsp_send_valid = send_ff;
   assign rsp_print_valid = print_ff;
   assign rsp_rx_pop = pop_ff;
   assign rsp_baud_kind = bkind_ff;
   assign rsp_baud_rate = quot_ff;
   assign rsp_irq_pulse = irq_ff;
   assign rsp_break_pulse = brk_ff;
   assign rsp_modem_lines = rep_ff[1:0];
   assign rsp_char_lengths = rep_ff[5:2];
   assign rsp_parity_stop = rep_ff[9:6];

endmodule

// ===== design/dual_serial_printer_port_regs.sv =====
// top level of the dual serial channel and printer port register block
// the result word is shown in the cycle after accept for reads, writes and ticks
// the second baud byte write with a nonzero count first runs the 17-bit divider
// a new request is taken only once the result word of the last one is taken
// reset: synchronous active high; port enabled, print char 0xff, rest zero but the result word and divider
module dual_serial_printer_port_regs
   import dspp_pkg::*;
#(
   parameter int TICK_PERIOD = TickPeriodDefault
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write,
   input  logic        csr_wdata,
   // request word
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_port,
   input  logic [7:0]  req_wdata,
   input  logic        req_rx_available,
   input  logic        req_clear_to_send,
   input  logic        req_tx_empty,
   input  logic        req_all_sent,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_printer_busy,
   // response word
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_rdata,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_send_valid,
   output logic        rsp_print_valid,
   output logic        rsp_rx_pop,
   output logic [1:0]  rsp_baud_kind,
   output logic [16:0] rsp_baud_rate,
   output logic        rsp_irq_pulse,
   output logic        rsp_break_pulse,
   output logic [1:0]  rsp_modem_lines,
   output logic [3:0]  rsp_char_lengths,
   output logic [3:0]  rsp_parity_stop
);

   cmd_type    cmd;
   status_type status;

   // sequencing of accept, divide and result hold
   dspp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd)
   );

   // register file, line settings tracking and baud divider
   dspp_path #(.TICK_PERIOD(TICK_PERIOD)) u_path (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .req_kind(req_kind), .req_port(req_port), .req_wdata(req_wdata),
      .req_rx_available(req_rx_available), .req_clear_to_send(req_clear_to_send),
      .req_tx_empty(req_tx_empty), .req_all_sent(req_all_sent),
      .req_rx_byte(req_rx_byte), .req_printer_busy(req_printer_busy),
      .rsp_rdata(rsp_rdata), .rsp_out_byte(rsp_out_byte),
      .rsp_send_valid(rsp_send_valid), .rsp_print_valid(rsp_print_valid),
      .rsp_rx_pop(rsp_rx_pop), .rsp_baud_kind(rsp_baud_kind),
      .rsp_baud_rate(rsp_baud_rate), .rsp_irq_pulse(rsp_irq_pulse),
      .rsp_break_pulse(rsp_break_pulse), .rsp_modem_lines(rsp_modem_lines),
      .rsp_char_lengths(rsp_char_lengths), .rsp_parity_stop(rsp_parity_stop)
   );

endmodule
